[src/mpmp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the max-plus matrix product block.
// No dependencies; used by the controller, datapath and top level of the block.
package mpmp_pkg;

   localparam int DIM_DEFAULT = 64;

   localparam int TYPE_W = 2;
   localparam int IDX_W  = 6;
   localparam int VAL_W  = 32;
   localparam int PROD_W = 32;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_LEFT  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_RIGHT = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic wr_left;
      logic wr_right;
      logic load;     // query accepted: latch indices, clear accumulator
      logic scan;     // issue reads for current k, advance k
      logic finish;   // register the answer onto the result port
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_range;
      logic k_last;
   } status_type;

endpackage

[src/mpmp_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mpmp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/mpmp_ctrl.sv]
`timescale 1ns / 1ps
// Controller FSM for the max-plus matrix product block.
// Depends on mpmp_pkg (request codes, command and status structs).
module mpmp_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mpmp_pkg::TYPE_W-1:0]    req_type,
   input  mpmp_pkg::status_type           status,
   output mpmp_pkg::cmd_type              cmd,
   output logic                           busy
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_WAIT1  = 3'd2;
   localparam logic [2:0] ST_WAIT2  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == mpmp_pkg::REQ_QUERY)) begin
               state_in = status.in_range ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (status.k_last) begin
               state_in = ST_WAIT1;
            end
         end
         ST_WAIT1:  state_in = ST_WAIT2;   // read data in flight
         ST_WAIT2:  state_in = ST_FINISH;  // last sum into accumulator
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.wr_left  = accept && (req_type == mpmp_pkg::REQ_LEFT) && status.in_range;
      cmd.wr_right = accept && (req_type == mpmp_pkg::REQ_RIGHT) && status.in_range;
      cmd.load     = accept && (req_type == mpmp_pkg::REQ_QUERY);
      cmd.scan     = (state_ff == ST_SCAN);
      cmd.finish   = (state_ff == ST_FINISH);
   end

endmodule

[src/mpmp_dpath.sv]
`timescale 1ns / 1ps
// Datapath: two matrix RAMs, index counter, add stage and max accumulator.
// Depends on mpmp_pkg and mpmp_ram.
module mpmp_dpath #(
   parameter int DIM = mpmp_pkg::DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mpmp_pkg::cmd_type                 cmd,
   output mpmp_pkg::status_type              status,
   input  logic [mpmp_pkg::IDX_W-1:0]        req_row,
   input  logic [mpmp_pkg::IDX_W-1:0]        req_col,
   input  logic signed [mpmp_pkg::VAL_W-1:0] req_value,
   output logic                              rsp_strobe,
   output logic [mpmp_pkg::PROD_W-1:0]       rsp_product
);

   localparam int DEPTH = DIM * DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int VW    = mpmp_pkg::VAL_W;
   localparam int PW    = mpmp_pkg::PROD_W;
   localparam logic [8:0] DIM_V = 9'(DIM);

   logic [IW-1:0]   row_ff, col_ff, k_ff;
   logic [AW-1:0]   wr_addr, left_raddr, right_raddr;
   logic [VW-1:0]   left_rdata, right_rdata;
   logic            rd_vld_ff, sum_vld_ff;
   logic signed [VW:0] sum_ff, sum_in;
   logic [PW-1:0]   acc_ff;
   logic            rsp_strobe_ff;
   logic [PW-1:0]   rsp_product_ff;

   assign status.in_range = ({3'b0, req_row} < DIM_V) && ({3'b0, req_col} < DIM_V);
   assign status.k_last   = (k_ff == IW'(DIM - 1));

   assign wr_addr     = AW'(AW'(req_row) * AW'(DIM) + AW'(req_col));
   assign left_raddr  = AW'(AW'(row_ff) * AW'(DIM) + AW'(k_ff));
   assign right_raddr = AW'(AW'(k_ff) * AW'(DIM) + AW'(col_ff));

   mpmp_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_left_ram (
      .clock (clock),
      .we    (cmd.wr_left),
      .waddr (wr_addr),
      .wdata (req_value),
      .raddr (left_raddr),
      .rdata (left_rdata)
   );

   mpmp_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_right_ram (
      .clock (clock),
      .we    (cmd.wr_right),
      .waddr (wr_addr),
      .wdata (req_value),
      .raddr (right_raddr),
      .rdata (right_rdata)
   );

   // sign-extended sum, 33 bits, never overflows
   assign sum_in = $signed({left_rdata[VW-1], left_rdata})
                 + $signed({right_rdata[VW-1], right_rdata});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff <= IW'(req_row);
         col_ff <= IW'(req_col);
         k_ff   <= '0;
      end else if (cmd.scan) begin
         k_ff <= k_ff + 1'b1;
      end
      sum_ff <= sum_in;
      if (cmd.load) begin
         acc_ff <= '0;   // max starts at zero: floors the answer
      end else if (sum_vld_ff && (sum_ff > $signed({1'b0, acc_ff}))) begin
         acc_ff <= sum_ff[PW-1:0];
      end
      if (cmd.finish) begin
         rsp_product_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff     <= 1'b0;
         sum_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rd_vld_ff     <= cmd.scan;
         sum_vld_ff    <= rd_vld_ff;
         rsp_strobe_ff <= cmd.finish;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_product = rsp_product_ff;

endmodule

[src/max_plus_matrix_product.sv]
`timescale 1ns / 1ps
// Max-plus (tropical) matrix product, top level.
// Depends on mpmp_pkg, mpmp_ctrl, mpmp_dpath (which uses mpmp_ram).
//
// Usage:
//   Request beats: drive start with req_type/req_row/req_col/req_value; the
//   beat is taken at a rising edge where start is high and busy is low.
//   req_type LEFT/RIGHT writes one entry of the left/right matrix (busy
//   stays low); out-of-range indices and code 3 are dropped.
//   req_type QUERY returns max over k of left[row][k] + right[k][col],
//   floored at zero, as one rsp_strobe beat on rsp_product.
// Query flow:
//   An in-range query scans DIM index pairs through one add stage and one
//   max stage, one pair per cycle. The RAM read register and the add
//   register lie between the reads and the max stage. An out-of-range
//   query skips the scan and answers 0.
//   A new request is taken in the same cycle the previous answer is shown.
// Reset: clears the controller and strobe; matrix contents are left as is
//   and are undefined until written. The result port cannot be stalled:
//   each answer is valid for exactly the one strobe cycle.
module max_plus_matrix_product #(
   parameter int DIM = mpmp_pkg::DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mpmp_pkg::TYPE_W-1:0]       req_type,
   input  logic [mpmp_pkg::IDX_W-1:0]        req_row,
   input  logic [mpmp_pkg::IDX_W-1:0]        req_col,
   input  logic signed [mpmp_pkg::VAL_W-1:0] req_value,
   output logic                              rsp_strobe,
   output logic [mpmp_pkg::PROD_W-1:0]       rsp_product
);

   mpmp_pkg::cmd_type    cmd;
   mpmp_pkg::status_type status;

   // sequencing: accept, scan DIM pairs, drain two stages, present answer
   mpmp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy)
   );

   // storage and arithmetic
   mpmp_dpath #(.DIM(DIM)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_value   (req_value),
      .rsp_strobe  (rsp_strobe),
      .rsp_product (rsp_product)
   );

endmodule
